### design/fbcb_pkg.sv
// ----------------------------------------------------------------------------
// fbcb_pkg
// Types and codes shared by the clipped-blit frame buffer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fbcb_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_BLIT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_CLIPPED = 2'd2;
  localparam logic [1:0] ST_CAP     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FB_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FB_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BPP       = 2'd2;

  localparam int CFG_DATA_W = 13;

  localparam logic [12:0] FB_WIDTH_RST  = 13'd1024;
  localparam logic [11:0] FB_HEIGHT_RST = 12'd768;
  localparam logic [5:0]  BPP_RST       = 6'd1;
  localparam logic [5:0]  BPP_MAX       = 6'd32;

  localparam logic [10:0] ROW_MAX = 11'd2047;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] src_width;
    logic [10:0] src_height;
    logic [11:0] start_x;
    logic [10:0] start_y;
    logic [7:0]  data_byte;
    logic        first;
    logic [16:0] read_address;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_PREP,
    S_CLRSET,
    S_CLEAR,
    S_WRITE,
    S_READ,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### design/fbcb_ram.sv
// ----------------------------------------------------------------------------
// fbcb_ram
// Generic single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### design/framebuffer_clipped_blit.sv
// ----------------------------------------------------------------------------
// framebuffer_clipped_blit
// Byte-addressed frame buffer with clear, clipped rectangle blit and byte read.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; exactly one
// result (status, read_data) follows, shown for one cycle while done is high.
// The receiver cannot stall, so capture the result on the done cycle. Blit
// bytes pass S_CALC, S_PREP, S_WRITE and S_DONE; reads pass S_CALC,
// S_PREP, S_READ and S_DONE; a rejected or clipped blit byte, a read
// beyond capacity or an unused op code goes from S_PREP to S_DONE.
// A clear passes S_CALC, S_PREP, S_CLRSET, then S_CLEAR, where the single
// RAM port zeroes one byte a cycle for N = min(fb_height * pitch, FB_BYTES)
// bytes. Two multiplier stages (byte widths, then row offset) and the one
// RAM port set this order. Frame store contents are undefined until
// cleared or written. Configuration may be written only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_clipped_blit
  import fbcb_pkg::*;
#(
  parameter int FB_BYTES = 131072
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire cmd_t                  cmd,
  output logic                       busy,
  output logic                       done,
  output res_t                       result,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(FB_BYTES);
  localparam int ADDR_W = 28;                 // widest blit address sum
  localparam logic [ADDR_W-1:0] FB_LIM = ADDR_W'(FB_BYTES);
  localparam logic [26:0]       FB_LIM_SZ = 27'(FB_BYTES);
  localparam logic [20:0]       FB_LIM_RD = 21'(FB_BYTES);

  // configuration
  logic [12:0] fb_width;
  logic [11:0] fb_height;
  logic [5:0]  bpp;

  // control
  state_t state, state_next;

  // transaction and datapath registers
  cmd_t         cmd_q;
  logic [14:0]  pitch_q;
  logic [13:0]  src_pitch_q;
  logic [13:0]  xb_q;
  logic [26:0]  size_q;
  logic [26:0]  prod_q;
  logic [13:0]  col_q;
  logic [1:0]   status_q;
  logic [7:0]   rd_q;
  logic [AW:0]  clr_cnt;
  logic [AW:0]  clr_limit;

  // blit position
  logic [10:0] src_row;
  logic [13:0] src_col;

  // RAM port
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  fbcb_ram #(
    .WIDTH(8),
    .DEPTH(FB_BYTES)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width  <= FB_WIDTH_RST;
      fb_height <= FB_HEIGHT_RST;
      bpp       <= BPP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FB_WIDTH:  fb_width  <= cfg_data;
        CFG_FB_HEIGHT: fb_height <= cfg_data[11:0];
        CFG_BPP:       bpp       <= cfg_data[5:0];
        default: ;                            // index beyond the list: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 (S_CALC): byte widths. bpp above 32 counts as 32.
  // --------------------------------------------------------------------------
  logic [5:0]  bpp_eff;
  logic [18:0] pitch_prod;
  logic [17:0] srcp_prod;
  logic [17:0] xb_prod;

  always_comb begin
    bpp_eff    = (bpp > BPP_MAX) ? BPP_MAX : bpp;
    pitch_prod = fb_width * 19'(bpp_eff);
    srcp_prod  = cmd_q.src_width * 18'(bpp_eff);
    xb_prod    = cmd_q.start_x * 18'(bpp_eff);
  end

  // --------------------------------------------------------------------------
  // Stage 2 (S_PREP): position, start and clip checks, row offset.
  // --------------------------------------------------------------------------
  logic [10:0] row_cur;
  logic [13:0] col_cur;
  logic [13:0] col_inc;
  logic        col_wrap;
  logic        zero_pitch;
  logic        outside;
  logic [14:0] cw;
  logic [11:0] ch;
  logic [11:0] row_sum;
  logic        clipped;
  logic        rd_oob;

  always_comb begin
    row_cur    = cmd_q.first ? '0 : src_row;
    col_cur    = cmd_q.first ? '0 : src_col;
    col_inc    = col_cur + 14'd1;
    col_wrap   = (col_inc >= src_pitch_q);
    zero_pitch = (src_pitch_q == '0);
    outside    = ({1'b0, cmd_q.start_x} > fb_width) ||
                 ({1'b0, cmd_q.start_y} > fb_height);
    // sums stay below 2**15 and 2**12, so no carry out
    cw = ((15'(src_pitch_q) + 15'(xb_q)) > pitch_q) ? (pitch_q - 15'(xb_q))
                                                    : 15'(src_pitch_q);
    ch = ((12'(cmd_q.src_height) + 12'(cmd_q.start_y)) > fb_height)
         ? (fb_height - 12'(cmd_q.start_y)) : 12'(cmd_q.src_height);
    clipped = ({1'b0, row_cur} >= ch) || ({1'b0, col_cur} >= cw);
    row_sum = 12'(cmd_q.start_y) + 12'(row_cur);
    rd_oob  = ({4'd0, cmd_q.read_address} >= FB_LIM_RD);
  end

  // Stage 3 (S_WRITE): final byte address
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_oob;

  always_comb begin
    wr_addr = ADDR_W'(prod_q) + ADDR_W'(xb_q) + ADDR_W'(col_q);
    wr_oob  = (wr_addr >= FB_LIM);
  end

  logic clr_last;
  assign clr_last = (clr_cnt == clr_limit - 1'b1);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_CALC;
      S_CALC:   state_next = S_PREP;
      S_PREP: begin
        unique case (cmd_q.op)
          OP_CLEAR: state_next = S_CLRSET;
          OP_BLIT:  state_next = (zero_pitch || outside || clipped) ? S_DONE : S_WRITE;
          OP_READ:  state_next = rd_oob ? S_DONE : S_READ;
          default:  state_next = S_DONE;
        endcase
      end
      S_CLRSET: state_next = (size_q == '0) ? S_DONE : S_CLEAR;
      S_CLEAR:  if (clr_last) state_next = S_DONE;
      S_WRITE:  state_next = S_DONE;
      S_READ:   state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    busy      = (state != S_IDLE);
    done      = (state == S_DONE);
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(cmd_q.read_address);
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_cnt[AW-1:0];
      end
      S_WRITE: begin
        ram_en    = !wr_oob;
        ram_we    = 1'b1;
        ram_addr  = wr_addr[AW-1:0];
        ram_wdata = cmd_q.data_byte;
      end
      S_PREP: begin
        ram_en = (cmd_q.op == OP_READ) && !rd_oob;
      end
      default: ;
    endcase
  end

  assign result.status    = status_q;
  assign result.read_data = rd_q;

  // --------------------------------------------------------------------------
  // Blit position (control state)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      src_row <= '0;
      src_col <= '0;
    end else if (state == S_PREP && cmd_q.op == OP_BLIT) begin
      if (zero_pitch) begin
        // position holds, but a first byte still rewinds it
        src_row <= row_cur;
        src_col <= col_cur;
      end else if (col_wrap) begin
        src_col <= '0;
        src_row <= (row_cur < ROW_MAX) ? row_cur + 11'd1 : row_cur;
      end else begin
        src_row <= row_cur;
        src_col <= col_inc;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q    <= cmd;
          status_q <= ST_OK;
          rd_q     <= '0;
        end
      end
      S_CALC: begin
        pitch_q     <= 15'(pitch_prod >> 3);
        src_pitch_q <= 14'(srcp_prod >> 3);
        xb_q        <= 14'(xb_prod >> 3);
      end
      S_PREP: begin
        size_q <= fb_height * 27'(pitch_q);
        prod_q <= row_sum * 27'(pitch_q);
        col_q  <= col_cur;
        if (cmd_q.op == OP_BLIT) begin
          if (zero_pitch)   status_q <= ST_CLIPPED;
          else if (outside) status_q <= ST_OUTSIDE;
          else if (clipped) status_q <= ST_CLIPPED;
        end else if (cmd_q.op == OP_READ && rd_oob) begin
          status_q <= ST_CAP;
        end
      end
      S_CLRSET: begin
        clr_cnt <= '0;
        if (size_q > FB_LIM_SZ) begin
          clr_limit <= (AW+1)'(FB_BYTES);
          status_q  <= ST_CAP;
        end else begin
          clr_limit <= (AW+1)'(size_q);
        end
      end
      S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
      S_WRITE: if (wr_oob) status_q <= ST_CAP;
      S_READ:  rd_q <= ram_rdata;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/fbcb_checker.sv
// ----------------------------------------------------------------------------
// fbcb_checker
// Port-level checks for the clipped-blit frame buffer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbcb_checker
  import fbcb_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire res_t result
);

  // a result only appears for a transaction in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // one result per transaction
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for two cycles");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accept did not start a transaction");

  // read data is nonzero only on a successful read
  a_rdata_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.read_data != 8'd0) |-> (result.status == ST_OK))
    else $error("read data with failing status");

endmodule

bind framebuffer_clipped_blit fbcb_checker u_fbcb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

`default_nettype wire
